// File: design/scf_pkg.sv
// Shared constants and handshake structs of the sampled content fingerprint.
// Used by scf_fmix and sampled_content_fingerprint_top; depends on nothing.
package scf_pkg;

	localparam int unsigned WORD_W  = 64;
	localparam int unsigned TOTAL_W = 48;
	localparam int unsigned COUNT_W = 19;
	localparam int unsigned GB_W    = 6;
	localparam int unsigned LANES   = 4;
	localparam int unsigned GROUP_W = WORD_W * LANES;

	localparam logic [GB_W-1:0] GROUP_MAX = 6'd32;

	localparam logic [WORD_W-1:0] SEED0  = 64'h9e3779b97f4a7c15;
	localparam logic [WORD_W-1:0] SEED1  = 64'hbf58476d1ce4e5b9;
	localparam logic [WORD_W-1:0] SEED2  = 64'h94d049bb133111eb;
	localparam logic [WORD_W-1:0] SEED3  = 64'h2545f4914f6cdd1d;
	localparam logic [WORD_W-1:0] MIX_K1 = 64'hff51afd7ed558ccd;
	localparam logic [WORD_W-1:0] MIX_K2 = 64'hc4ceb9fe1a85ec53;
	localparam int unsigned MIX_SHIFT = 33;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] operand;
	} scf_fmix_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
	} scf_fmix_rsp_t;

endpackage

// File: design/scf_fmix.sv
// Iterative 64-bit finalizer mix built around one shared 32x32 multiplier.
// Depends on scf_pkg for the mix constants and the request/response structs.
module scf_fmix
	import scf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  scf_fmix_req_t req,
	output scf_fmix_rsp_t rsp
);

	typedef enum logic [4:0] {
		F_IDLE = 5'b00001,
		F_MUL0 = 5'b00010,
		F_MUL1 = 5'b00100,
		F_MUL2 = 5'b01000,
		F_XS   = 5'b10000
	} fmix_state_t;

	fmix_state_t       f_q;
	logic              phase_q;
	logic [WORD_W-1:0] v_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] k;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       prod;

	function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
		return v ^ (v >> MIX_SHIFT);
	endfunction

	assign k = phase_q ? MIX_K2 : MIX_K1;

	// The low 64 bits of a 64x64 product need three partial products:
	// lo*lo in full, then the low halves of the two cross products.
	always_comb begin
		case (f_q)
			F_MUL1: begin
				mul_a = v_q[63:32];
				mul_b = k[31:0];
			end
			F_MUL2: begin
				mul_a = v_q[31:0];
				mul_b = k[63:32];
			end
			default: begin
				mul_a = v_q[31:0];
				mul_b = k[31:0];
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q     <= F_IDLE;
			phase_q <= 1'b0;
		end else begin
			case (f_q)
				F_IDLE: begin
					if (req.start) begin
						phase_q <= 1'b0;
						f_q     <= F_MUL0;
					end
				end
				F_MUL0: f_q <= F_MUL1;
				F_MUL1: f_q <= F_MUL2;
				F_MUL2: f_q <= F_XS;
				F_XS: begin
					if (phase_q) begin
						f_q <= F_IDLE;
					end else begin
						phase_q <= 1'b1;
						f_q     <= F_MUL0;
					end
				end
				default: f_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (f_q)
			F_IDLE: begin
				if (req.start) begin
					v_q <= xorshift(req.operand);
				end
			end
			F_MUL0: acc_q <= prod;
			F_MUL1, F_MUL2: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			F_XS: v_q <= xorshift(acc_q);
			default: ;
		endcase
	end

	assign rsp.done   = (f_q == F_XS) && phase_q;
	assign rsp.result = xorshift(acc_q);

endmodule

// File: design/sampled_content_fingerprint_top.sv
// Top level of the sampled content fingerprint: beat sequencer, lane state
// and output register. Depends on scf_pkg and scf_fmix.
//
//  Channel  | Signals                                  | Carries
//  ---------+------------------------------------------+-------------------------------
//  s_axis   | tvalid tready tdata[263:0] tuser tlast  | one group of up to 32 bytes
//  m_axis   | tvalid tready tdata[63:0]                | fingerprint
//  cfg      | valid ready data[47:0]                   | total_bytes, restarts the hash
//
// One finalizer mix is an issue, then two passes of multiply steps and an xor-shift
// step on the shared 32x32 multiplier. An accepted beat runs four lane mixes for a full
// group, shifts in the bytes of a partial tail and mixes the tail at a chunk end, and
// folds the four lanes on the last group. s_axis_tready is high only while the sequencer
// is idle; a finished fingerprint waits in the output register, and only the next one
// stalls on it.
module sampled_content_fingerprint_top
	import scf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [263:0]       s_axis_tdata,  // word0, word1, word2, word3, group_bytes, pad
	input  logic               s_axis_tuser,  // chunk_end
	input  logic               s_axis_tlast,  // last_group
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [WORD_W-1:0]  m_axis_tdata,  // fingerprint
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [TOTAL_W-1:0] cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LANE = 6'b000010,
		ST_TAIL = 6'b000100,
		ST_TMIX = 6'b001000,
		ST_FOLD = 6'b010000,
		ST_OUT  = 6'b100000
	} seq_state_t;

	seq_state_t         state_q;
	logic [WORD_W-1:0]  lane_q [LANES];
	logic [TOTAL_W-1:0] total_q;
	logic [COUNT_W-1:0] count_q;
	logic [GROUP_W-1:0] w_q;
	logic [GB_W-1:0]    gb_q;
	logic               cend_q;
	logic               last_q;
	logic [1:0]         idx_q;
	logic [4:0]         k_q;
	logic               issued_q;
	logic [WORD_W-1:0]  tail_q;
	logic [WORD_W-1:0]  h_q;
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_data_q;

	logic               in_fire;
	logic               cfg_fire;
	logic               busy_mix;
	logic [GB_W-1:0]    gb_in;
	logic [GB_W-1:0]    gb_sat;
	logic [GB_W-1:0]    gb_eff;
	logic [COUNT_W-1:0] len;
	logic [7:0]         tail_byte;
	logic               out_load;
	scf_fmix_req_t      mix_req;
	scf_fmix_rsp_t      mix_rsp;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_fire      = cfg_valid && cfg_ready;

	assign gb_in  = s_axis_tdata[GROUP_W +: GB_W];
	assign gb_sat = (gb_in > GROUP_MAX) ? GROUP_MAX : gb_in;
	assign gb_eff = s_axis_tuser ? gb_sat : GROUP_MAX;
	assign len    = count_q + COUNT_W'(gb_eff);

	assign tail_byte = w_q[{k_q, 3'b000} +: 8];
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	assign busy_mix = (state_q == ST_LANE) || (state_q == ST_TMIX) || (state_q == ST_FOLD);

	always_comb begin
		mix_req.start = busy_mix && !issued_q;
		case (state_q)
			ST_LANE: mix_req.operand = lane_q[idx_q] ^ w_q[{idx_q, 6'b000000} +: WORD_W];
			ST_TMIX: mix_req.operand = lane_q[0] ^ tail_q;
			ST_FOLD: mix_req.operand = h_q ^ lane_q[idx_q];
			default: mix_req.operand = '0;
		endcase
	end

	scf_fmix u_fmix (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mix_req),
		.rsp    (mix_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			total_q   <= '0;
			count_q   <= '0;
			idx_q     <= '0;
			issued_q  <= 1'b0;
			lane_q[0] <= SEED0;
			lane_q[1] <= SEED1;
			lane_q[2] <= SEED2;
			lane_q[3] <= SEED3;
		end else if (cfg_fire) begin
			total_q   <= cfg_data;
			count_q   <= '0;
			lane_q[0] <= SEED0 ^ WORD_W'(cfg_data);
			lane_q[1] <= SEED1;
			lane_q[2] <= SEED2;
			lane_q[3] <= SEED3;
		end else begin
			if (mix_req.start) begin
				issued_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						idx_q   <= '0;
						count_q <= s_axis_tuser ? '0 : count_q + COUNT_W'(GROUP_MAX);
						if (gb_eff == GROUP_MAX) begin
							state_q <= ST_LANE;
						end else if (gb_eff == '0) begin
							state_q <= ST_TMIX;
						end else begin
							state_q <= ST_TAIL;
						end
					end
				end
				ST_LANE: begin
					if (mix_rsp.done) begin
						issued_q      <= 1'b0;
						lane_q[idx_q] <= mix_rsp.result;
						idx_q         <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							// A full group at a chunk end has no trailing bytes.
							if (cend_q) begin
								state_q <= ST_TMIX;
							end else if (last_q) begin
								state_q <= ST_FOLD;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_TAIL: begin
					if ({1'b0, k_q} == gb_q - 6'd1) begin
						state_q <= ST_TMIX;
					end
				end
				ST_TMIX: begin
					if (mix_rsp.done) begin
						issued_q  <= 1'b0;
						lane_q[0] <= mix_rsp.result;
						state_q   <= last_q ? ST_FOLD : ST_IDLE;
					end
				end
				ST_FOLD: begin
					if (mix_rsp.done) begin
						issued_q <= 1'b0;
						idx_q    <= idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q   <= ST_IDLE;
						count_q   <= '0;
						lane_q[0] <= SEED0 ^ WORD_W'(total_q);
						lane_q[1] <= SEED1;
						lane_q[2] <= SEED2;
						lane_q[3] <= SEED3;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Beat payload, tail word and fold accumulator.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			w_q    <= s_axis_tdata[GROUP_W-1:0];
			gb_q   <= gb_eff;
			cend_q <= s_axis_tuser;
			last_q <= s_axis_tlast;
			k_q    <= '0;
			tail_q <= WORD_W'(len);
			h_q    <= WORD_W'(total_q);
		end else if (state_q == ST_TAIL) begin
			tail_q <= {tail_q[WORD_W-9:0], 8'h00} ^ WORD_W'(tail_byte);
			k_q    <= k_q + 5'd1;
		end else if (state_q == ST_FOLD && mix_rsp.done) begin
			h_q <= mix_rsp.result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= h_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_done_in_mix_state: assert property (@(posedge clk) disable iff (!arst_n)
		mix_rsp.done |-> busy_mix && issued_q)
		else $error("finalizer finished outside a mixing state");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
		else $error("output loaded without a completed fold");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !cfg_fire |=> state_q != ST_IDLE)
		else $error("accepted beat did not start the sequencer");

	a_tail_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TAIL |-> ({1'b0, k_q} < gb_q) && (gb_q < GROUP_MAX))
		else $error("tail byte index out of range");

endmodule
